// ----- rtl/afc_pkg.sv -----
// shared types and constants of the box frustum cull unit
// plane record, pipeline enable group, field widths and operation codes
// no dependencies
package afc_pkg;

	localparam int COORD_W = 32;
	localparam int EXT_W   = 31;
	localparam int SLOT_W  = 3;
	localparam int COUNT_W = 3;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 64;
	localparam int HPROD_W = COORD_W + EXT_W;
	// six products of at most 2^62 each plus the shifted offset stay below 2^65
	localparam int SUM_W   = 67;

	localparam logic [COUNT_W-1:0] PLANE_COUNT_RST = 3'd6;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef logic [2:0][COORD_W-1:0] vec_t;
	typedef logic [2:0][EXT_W-1:0] ext_t;

	typedef struct packed {
		vec_t               n;
		logic [COORD_W-1:0] d;
	} plane_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_ctl_t;

endpackage

// ----- rtl/afc_plane_store.sv -----
// plane register file: one normal and offset per slot, cleared at reset
// depends on afc_pkg
module afc_plane_store #(
	parameter int MAX_PLANES = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [afc_pkg::SLOT_W-1:0]   wr_slot,
	input  afc_pkg::plane_t              wr_plane,
	output afc_pkg::plane_t              planes [MAX_PLANES]
);

	afc_pkg::plane_t plane_q [MAX_PLANES];

	for (genvar k = 0; k < MAX_PLANES; k++) begin : g_slot
		// slots at or above the depth never match and are dropped
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				plane_q[k] <= '0;
			end else if (wr_en && wr_slot == afc_pkg::SLOT_W'(k)) begin
				plane_q[k] <= wr_plane;
			end
		end
		assign planes[k] = plane_q[k];
	end

endmodule

// ----- rtl/afc_plane_lane.sv -----
// one plane lane: products, two adder levels, final sign of the corner sum
// depends on afc_pkg
module afc_plane_lane (
	input  logic                clk,
	input  afc_pkg::pipe_ctl_t  ctl,
	input  afc_pkg::plane_t     plane,
	input  afc_pkg::vec_t       pos,
	input  afc_pkg::ext_t       half,
	output logic                reject_s5
);

	logic        [afc_pkg::COORD_W-1:0] mag [3];
	logic signed [afc_pkg::PROD_W-1:0]  prod_s2 [3];
	logic        [afc_pkg::HPROD_W-1:0] hprod_s2 [3];
	logic signed [afc_pkg::COORD_W-1:0] off_s2;
	logic signed [afc_pkg::SUM_W-1:0]   part_s3 [4];
	logic signed [afc_pkg::SUM_W-1:0]   part_s4 [2];
	logic signed [afc_pkg::SUM_W-1:0]   total;

	// magnitude of each normal component, the most negative value maps to 2^31
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag[a] = plane.n[a][afc_pkg::COORD_W-1] ? (~plane.n[a] + 1'b1) : plane.n[a];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int a = 0; a < 3; a++) begin
				prod_s2[a]  <= $signed(plane.n[a]) * $signed(pos[a]);
				hprod_s2[a] <= mag[a] * half[a];
			end
			off_s2 <= $signed(plane.d);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			part_s3[0] <= afc_pkg::SUM_W'(prod_s2[0]) + afc_pkg::SUM_W'(prod_s2[1]);
			part_s3[1] <= afc_pkg::SUM_W'(prod_s2[2]) + afc_pkg::SUM_W'(hprod_s2[0]);
			part_s3[2] <= afc_pkg::SUM_W'(hprod_s2[1]) + afc_pkg::SUM_W'(hprod_s2[2]);
			part_s3[3] <= afc_pkg::SUM_W'(off_s2) <<< afc_pkg::FRAC_W;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			part_s4[0] <= part_s3[0] + part_s3[1];
			part_s4[1] <= part_s3[2] + part_s3[3];
		end
	end

	assign total = part_s4[0] + part_s4[1];

	// largest corner value negative: every corner is outside this plane
	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			reject_s5 <= total[afc_pkg::SUM_W-1];
		end
	end

endmodule

// ----- rtl/aabb_frustum_cull_unit.sv -----
// top level of the box frustum cull unit: input stage, plane store, plane lanes, result
// depends on afc_pkg, afc_plane_store, afc_plane_lane
//
//   channel   signals                                   direction  notes
//   item      item_valid, item_stall, operation, ...    in         load or test request
//   result    result_valid, result_stall, visible       out        one per test request
//   config    cfg_we, cfg_data                          in         plane_count, write only
//
// one request per cycle sustained while result_stall is low; a test result passes through
// the products, two adder levels, sign and result register behind the input stage
// a load writes the store as it leaves the input stage, so every later test sees it
// reset clears the plane store to zero, plane_count to six and all valid bits
// each stage holds only when full and the stage after it holds, so bubbles close up
// behind a stalled result and nothing is dropped or repeated
module aabb_frustum_cull_unit #(
	parameter int MAX_PLANES = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          operation,
	input  logic [afc_pkg::SLOT_W-1:0]    plane_slot,
	input  logic signed [afc_pkg::COORD_W-1:0] vector_x,
	input  logic signed [afc_pkg::COORD_W-1:0] vector_y,
	input  logic signed [afc_pkg::COORD_W-1:0] vector_z,
	input  logic [afc_pkg::EXT_W-1:0]     extent_x,
	input  logic [afc_pkg::EXT_W-1:0]     extent_y,
	input  logic [afc_pkg::EXT_W-1:0]     extent_z,
	input  logic signed [afc_pkg::COORD_W-1:0] plane_offset,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          visible,
	input  logic                          cfg_we,
	input  logic [afc_pkg::COUNT_W-1:0]   cfg_data
);

	// configuration
	logic [afc_pkg::COUNT_W-1:0] plane_count_q;

	// input stage
	logic                        valid_s1;
	logic                        op_s1;
	logic [afc_pkg::SLOT_W-1:0]  slot_s1;
	afc_pkg::vec_t               vec_s1;
	afc_pkg::ext_t               ext_s1;
	logic [afc_pkg::COORD_W-1:0] off_s1;

	// valid bits of the lane stages and the result register
	logic valid_s2, valid_s3, valid_s4, valid_s5;
	logic result_valid_q, visible_q;

	// backward ready chain
	logic rdy_out, rdy_s5, rdy_s4, rdy_s3, rdy_s2, leave_s1;

	afc_pkg::pipe_ctl_t ctl;
	afc_pkg::plane_t    wr_plane;
	afc_pkg::plane_t    planes [MAX_PLANES];
	logic [MAX_PLANES-1:0] reject_s5;
	logic [MAX_PLANES-1:0] active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= afc_pkg::PLANE_COUNT_RST;
		end else if (cfg_we) begin
			plane_count_q <= cfg_data;
		end
	end

	// a stage may take new contents when empty or when its successor moves
	assign rdy_out  = !result_valid_q || !result_stall;
	assign rdy_s5   = !valid_s5 || rdy_out;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	// a load leaves the input stage at once, it only writes the store
	assign leave_s1 = !valid_s1 || op_s1 == afc_pkg::OP_LOAD || rdy_s2;

	assign item_stall = !leave_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (leave_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s1 && item_valid) begin
			op_s1     <= operation;
			slot_s1   <= plane_slot;
			vec_s1[0] <= vector_x;
			vec_s1[1] <= vector_y;
			vec_s1[2] <= vector_z;
			ext_s1[0] <= extent_x;
			ext_s1[1] <= extent_y;
			ext_s1[2] <= extent_z;
			off_s1    <= plane_offset;
		end
	end

	// plane store, written in order with the tests behind it
	assign wr_plane.n = vec_s1;
	assign wr_plane.d = off_s1;

	afc_plane_store #(
		.MAX_PLANES (MAX_PLANES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (valid_s1 && op_s1 == afc_pkg::OP_LOAD),
		.wr_slot  (slot_s1),
		.wr_plane (wr_plane),
		.planes   (planes)
	);

	// only tests travel past the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				valid_s2 <= valid_s1 && op_s1 == afc_pkg::OP_TEST;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	assign ctl.en_s2 = rdy_s2;
	assign ctl.en_s3 = rdy_s3;
	assign ctl.en_s4 = rdy_s4;
	assign ctl.en_s5 = rdy_s5;

	// one lane per plane slot, all planes tested in parallel
	for (genvar k = 0; k < MAX_PLANES; k++) begin : g_lane
		afc_plane_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.plane     (planes[k]),
			.pos       (vec_s1),
			.half      (ext_s1),
			.reject_s5 (reject_s5[k])
		);
		// counts above the slot depth simply enable every lane
		assign active[k] = afc_pkg::COUNT_W'(k) < plane_count_q;
	end

	// result register: culled when any active plane rejects
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rdy_out) begin
			result_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s5) begin
			visible_q <= !(|(reject_s5 & active));
		end
	end

	assign result_valid = result_valid_q;
	assign visible      = visible_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench of the box frustum cull unit: directed and random load and test requests
// with a scoreboard class that predicts the visible bit of each test request
// depends on afc_pkg and aabb_frustum_cull_unit
module tb_top;

	localparam int NUM_SLOTS  = 6;
	// time from acceptance to result, with margin for loads still in flight
	localparam int DRAIN_CYC  = 12;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_REQS = 112;

	localparam logic [afc_pkg::COORD_W-1:0] Q_ONE     = 32'h0001_0000;
	localparam logic [afc_pkg::COORD_W-1:0] Q_NEG_ONE = 32'hffff_0000;
	localparam logic [afc_pkg::COORD_W-1:0] C_MIN     = 32'h8000_0000;
	localparam logic [afc_pkg::COORD_W-1:0] C_MAX     = 32'h7fff_ffff;
	localparam logic [afc_pkg::EXT_W-1:0]   E_MAX     = 31'h7fff_ffff;

	// one request on the item channel
	typedef struct packed {
		logic                        op;
		logic [afc_pkg::SLOT_W-1:0]  slot;
		afc_pkg::vec_t               v;
		afc_pkg::ext_t               e;
		logic [afc_pkg::COORD_W-1:0] d;
	} cull_req_t;

	// mirror of the plane store and plane_count, plus the visible bits still owed
	class cull_scoreboard;
		afc_pkg::plane_t             planes [NUM_SLOTS];
		logic [afc_pkg::COUNT_W-1:0] plane_count;
		bit                          visible_q [$];
		int                          errors;

		function new();
			foreach (planes[i])
				planes[i] = '0;
			plane_count = afc_pkg::PLANE_COUNT_RST;
			errors = 0;
		endfunction

		function void set_count(logic [afc_pkg::COUNT_W-1:0] cnt);
			plane_count = cnt;
		endfunction

		// largest corner value per plane: n.c + |n|.e + d<<16, exact in 70 bits
		function bit box_visible(afc_pkg::vec_t c, afc_pkg::ext_t e);
			logic signed [69:0] acc;
			logic signed [69:0] nv;
			logic signed [69:0] mag;
			int active;
			int k;
			int a;
			box_visible = 1'b1;
			active = (plane_count > NUM_SLOTS) ? NUM_SLOTS : int'(plane_count);
			for (k = 0; k < active; k++) begin
				acc = '0;
				for (a = 0; a < 3; a++) begin
					nv = $signed(planes[k].n[a]);
					mag = (nv < 0) ? -nv : nv;
					acc = acc + nv * $signed(c[a]) + mag * $signed({1'b0, e[a]});
				end
				nv = $signed(planes[k].d);
				acc = acc + nv * 70'sd65536;
				if (acc < 0)
					box_visible = 1'b0;
			end
		endfunction

		function void note_request(cull_req_t r);
			if (r.op == afc_pkg::OP_LOAD) begin
				// slots past the store are dropped
				if (r.slot < NUM_SLOTS) begin
					planes[r.slot].n = r.v;
					planes[r.slot].d = r.d;
				end
			end else begin
				visible_q.insert(visible_q.size(), box_visible(r.v, r.e));
			end
		endfunction

		function void check_visible(logic vis);
			bit want;
			if (visible_q.size() == 0) begin
				$display("%0t: result with nothing pending, expected none actual %0b",
					$time, vis);
				errors++;
			end else begin
				want = visible_q.pop_front();
				if (vis !== want) begin
					$display("%0t: visible mismatch, expected %0b actual %0b",
						$time, want, vis);
					errors++;
				end
			end
		endfunction

		function int pending();
			return visible_q.size();
		endfunction
	endclass

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               item_valid   = 1'b0;
	logic                               item_stall;
	logic                               operation    = afc_pkg::OP_LOAD;
	logic [afc_pkg::SLOT_W-1:0]         plane_slot   = '0;
	logic signed [afc_pkg::COORD_W-1:0] vector_x     = '0;
	logic signed [afc_pkg::COORD_W-1:0] vector_y     = '0;
	logic signed [afc_pkg::COORD_W-1:0] vector_z     = '0;
	logic [afc_pkg::EXT_W-1:0]          extent_x     = '0;
	logic [afc_pkg::EXT_W-1:0]          extent_y     = '0;
	logic [afc_pkg::EXT_W-1:0]          extent_z     = '0;
	logic signed [afc_pkg::COORD_W-1:0] plane_offset = '0;
	logic                               result_valid;
	logic                               result_stall = 1'b0;
	logic                               visible;
	logic                               cfg_we       = 1'b0;
	logic [afc_pkg::COUNT_W-1:0]        cfg_data     = '0;

	// both sides run without gaps while this is set
	bit quiet = 1'b0;

	cull_scoreboard sb = new();

	aabb_frustum_cull_unit #(
		.MAX_PLANES(NUM_SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.plane_slot   (plane_slot),
		.vector_x     (vector_x),
		.vector_y     (vector_y),
		.vector_z     (vector_z),
		.extent_x     (extent_x),
		.extent_y     (extent_y),
		.extent_z     (extent_z),
		.plane_offset (plane_offset),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.visible      (visible),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// hard stop in case a handshake never completes
	initial begin
		#2000000;
		$display("aabb_frustum_cull_unit test failed");
		$finish;
	end

	// watch both channels at the clock edge; inputs only change by nonblocking writes
	always @(posedge clk) begin
		if (item_valid && !item_stall)
			sb.note_request({operation, plane_slot, {vector_z, vector_y, vector_x},
				{extent_z, extent_y, extent_x}, plane_offset});
		if (result_valid && !result_stall)
			sb.check_visible(visible);
	end

	// result side: stall for a random number of cycles, possibly none, before taking each result
	initial begin : result_side
		int gap;
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	function automatic afc_pkg::vec_t mk_vec(logic [afc_pkg::COORD_W-1:0] x,
		logic [afc_pkg::COORD_W-1:0] y, logic [afc_pkg::COORD_W-1:0] z);
		return {z, y, x};
	endfunction

	function automatic afc_pkg::ext_t mk_ext(logic [afc_pkg::EXT_W-1:0] x,
		logic [afc_pkg::EXT_W-1:0] y, logic [afc_pkg::EXT_W-1:0] z);
		return {z, y, x};
	endfunction

	function automatic cull_req_t mk_load(logic [afc_pkg::SLOT_W-1:0] slot, afc_pkg::vec_t n,
		logic [afc_pkg::COORD_W-1:0] d);
		cull_req_t r;
		r.op = afc_pkg::OP_LOAD;
		r.slot = slot;
		r.v = n;
		r.e = mk_ext(afc_pkg::EXT_W'($urandom), afc_pkg::EXT_W'($urandom),
			afc_pkg::EXT_W'($urandom));
		r.d = d;
		return r;
	endfunction

	function automatic cull_req_t mk_test(afc_pkg::vec_t c, afc_pkg::ext_t e);
		cull_req_t r;
		r.op = afc_pkg::OP_TEST;
		r.slot = afc_pkg::SLOT_W'($urandom_range(0, 7));
		r.v = c;
		r.e = e;
		r.d = $urandom;
		return r;
	endfunction

	// wide mode spans the full word, narrow mode stays within about +-16.0
	function automatic logic [afc_pkg::COORD_W-1:0] rand_coord(bit wide);
		int v;
		if (wide)
			return $urandom;
		v = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
		return v;
	endfunction

	function automatic logic [afc_pkg::EXT_W-1:0] rand_extent(bit wide);
		if ($urandom_range(0, 7) == 0)
			return '0;
		if (wide)
			return afc_pkg::EXT_W'($urandom);
		return afc_pkg::EXT_W'($urandom_range(0, 2 ** 19));
	endfunction

	function automatic cull_req_t rand_load(bit wide);
		cull_req_t r;
		int a;
		r = mk_load(afc_pkg::SLOT_W'($urandom_range(0, 5)), mk_vec(rand_coord(wide),
			rand_coord(wide), rand_coord(wide)), rand_coord(wide));
		// occasional write past the store
		if ($urandom_range(0, 9) == 0)
			r.slot = afc_pkg::SLOT_W'($urandom_range(NUM_SLOTS, 7));
		// axis aligned unit normals make exact boundary hits reachable
		if ($urandom_range(0, 9) < 4) begin
			a = $urandom_range(0, 2);
			r.v = '0;
			r.v[a] = $urandom_range(0, 1) ? Q_ONE : Q_NEG_ONE;
		end
		return r;
	endfunction

	function automatic cull_req_t rand_test(bit wide);
		cull_req_t r;
		afc_pkg::plane_t p;
		longint tgt;
		longint pos;
		int delta;
		int a;
		r = mk_test(mk_vec(rand_coord(wide), rand_coord(wide), rand_coord(wide)),
			mk_ext(rand_extent(wide), rand_extent(wide), rand_extent(wide)));
		if ($urandom_range(0, 4) == 0) begin
			// aim the box at the plane of a random slot: zero, or one step either side
			p = sb.planes[$urandom_range(0, NUM_SLOTS - 1)];
			for (a = 0; a < 3; a++) begin
				if (($signed(p.n[a]) == 65536 || $signed(p.n[a]) == -65536) &&
					p.n[(a + 1) % 3] == '0 && p.n[(a + 2) % 3] == '0) begin
					tgt = longint'($signed(p.d)) + longint'(r.e[a]);
					delta = int'($urandom_range(0, 2)) - 1;
					pos = ($signed(p.n[a]) > 0) ? delta - tgt : tgt - delta;
					r.v[a] = pos[afc_pkg::COORD_W-1:0];
				end
			end
		end
		return r;
	endfunction

	// present one request after a random gap and hold it until it is taken
	task automatic send_request(cull_req_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		operation    <= r.op;
		plane_slot   <= r.slot;
		vector_x     <= r.v[0];
		vector_y     <= r.v[1];
		vector_z     <= r.v[2];
		extent_x     <= r.e[0];
		extent_y     <= r.e[1];
		extent_z     <= r.e[2];
		plane_offset <= r.d;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// all results in, then let any trailing loads leave the pipeline
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_count(logic [afc_pkg::COUNT_W-1:0] cnt);
		cfg_we   <= 1'b1;
		cfg_data <= cnt;
		@(posedge clk);
		cfg_we   <= 1'b0;
		sb.set_count(cnt);
	endtask

	// one setting of plane_count: fresh planes in some slots, then a random mix
	task automatic run_phase(logic [afc_pkg::COUNT_W-1:0] cnt);
		cull_req_t r;
		int mode;
		int s;
		int i;
		bit wide;
		wait_idle();
		write_count(cnt);
		mode = $urandom_range(0, 2);
		quiet = ($urandom_range(0, 3) == 0);
		for (s = 0; s < NUM_SLOTS; s++) begin
			if ($urandom_range(0, 1)) begin
				r = rand_load(mode == 2 ? bit'($urandom_range(0, 1)) : bit'(mode));
				r.slot = afc_pkg::SLOT_W'(s);
				send_request(r);
			end
		end
		for (i = 0; i < PHASE_REQS; i++) begin
			if (i % 40 == 39)
				quiet = ($urandom_range(0, 3) == 0);
			wide = (mode == 2) ? bit'($urandom_range(0, 1)) : bit'(mode);
			r = ($urandom_range(0, 99) < 30) ? rand_load(wide) : rand_test(wide);
			send_request(r);
		end
	endtask

	initial begin : stimulus
		logic [afc_pkg::COUNT_W-1:0] phase_counts [NUM_PHASES];
		cull_req_t edge_box;
		int p;
		phase_counts = '{3'd6, 3'd0, 3'd1, 3'd7, 3'd3, 3'd6, 3'd2, 3'd5, 3'd4, 3'd6};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// untouched store is all zero: every box stays visible
		send_request(mk_test('0, '0));
		send_request(mk_test(mk_vec(C_MIN, C_MIN, C_MIN), mk_ext(E_MAX, E_MAX, E_MAX)));

		// plane x >= 0 in slot 0; a corner exactly on it counts as inside
		send_request(mk_load(3'd0, mk_vec(Q_ONE, '0, '0), '0));
		send_request(mk_test(mk_vec(-32'sd100, '0, '0), mk_ext(31'd100, '0, '0)));
		edge_box = mk_test(mk_vec(-32'sd101, '0, '0), mk_ext(31'd100, '0, '0));
		send_request(edge_box);

		// writes past the store must not disturb anything
		send_request(mk_load(3'd6, mk_vec(Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE), C_MIN));
		send_request(mk_load(3'd7, mk_vec(C_MAX, C_MAX, C_MAX), C_MAX));
		send_request(edge_box);

		// extreme normals and offsets against extreme boxes
		send_request(mk_load(3'd5, mk_vec(C_MIN, C_MIN, C_MIN), C_MIN));
		send_request(mk_test(mk_vec(C_MAX, C_MAX, C_MAX), '0));
		send_request(mk_test(mk_vec(C_MIN, C_MIN, C_MIN), mk_ext(E_MAX, E_MAX, E_MAX)));
		send_request(mk_load(3'd1, mk_vec(C_MAX, C_MAX, C_MAX), C_MAX));
		send_request(mk_test('0, mk_ext(E_MAX, E_MAX, E_MAX)));
		send_request(mk_test(mk_vec(C_MAX, C_MIN, C_MAX), mk_ext('0, E_MAX, '0)));

		// no active planes, then a count past the store, then a single plane
		wait_idle();
		write_count(3'd0);
		send_request(edge_box);
		wait_idle();
		write_count(3'd7);
		send_request(edge_box);
		wait_idle();
		write_count(3'd1);
		send_request(edge_box);

		for (p = 0; p < NUM_PHASES; p++)
			run_phase(phase_counts[p]);

		wait_idle();
		repeat (2 * DRAIN_CYC) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("aabb_frustum_cull_unit test passed");
		end else begin
			$display("aabb_frustum_cull_unit test failed");
		end
		$finish;
	end

endmodule
